>>> hdl/icv_pkg.sv
// Package for the 3x3 image convolution block.
// Holds field widths, register indexes and the item control struct.
// No dependencies.
package icv_pkg;

  localparam int PIX_BITS   = 8;
  localparam int COEF_BITS  = 16;
  localparam int ROW_COEFS  = 3;
  localparam int KROW_BITS  = COEF_BITS * ROW_COEFS;
  localparam int TAP_COUNT  = ROW_COEFS * ROW_COEFS;
  localparam int DIM_BITS   = 12;
  localparam int ROW_BITS   = DIM_BITS + 1;
  localparam int CHCFG_BITS = 3;
  localparam int IDX_BITS   = 3;
  localparam int PIX_MAX    = 255;

  typedef logic [PIX_BITS-1:0] pix_t;

  // Configuration register indexes
  typedef enum logic [IDX_BITS-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_KERNEL_TOP    = 3'd3,
    REG_KERNEL_MIDDLE = 3'd4,
    REG_KERNEL_BOTTOM = 3'd5
  } reg_index_t;

  // Per-item control that travels with a byte through the window stage
  typedef struct packed {
    logic up_ok;     // upper line store holds this frame's data
    logic lo_ok;     // lower line store holds this frame's data
    logic emit;      // item produces a result
    logic done;      // result is the last of the frame
    logic top_ok;    // output row has a row above
    logic bot_ok;    // output row has a row below
    logic left_ok;   // output column has a column to the left
    logic right_ok;  // output column has a column to the right
    pix_t newv;      // byte entering the window (zero past the frame)
  } icv_item_t;

endpackage

>>> hdl/icv_in_if.sv
// Input stream interface: valid/ready with mode and pixel byte.
// Depends on icv_pkg.
interface icv_in_if import icv_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  pix_t pixel_value;

  modport source(output valid, mode, pixel_value, input ready);
  modport sink(input valid, mode, pixel_value, output ready);
endinterface

>>> hdl/icv_out_if.sv
// Output stream interface: valid/ready with filtered byte and frame end flag.
// Depends on icv_pkg.
interface icv_out_if import icv_pkg::*; ();
  logic valid;
  logic ready;
  pix_t filtered_value;
  logic frame_done;

  modport source(output valid, filtered_value, frame_done, input ready);
  modport sink(input valid, filtered_value, frame_done, output ready);
endinterface

>>> hdl/icv_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module icv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/icv_seq.sv
// Position sequencer: input and output row/column/channel counters,
// line store address, flush handling and frame end. Depends on icv_pkg.
module icv_seq import icv_pkg::*; #(
  parameter int ADDR_BITS = 13,
  parameter int CIDX = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 proc,
  input  logic                 mode,
  input  pix_t                 pixel_value,
  input  logic [DIM_BITS-1:0]  w_m1,
  input  logic [DIM_BITS-1:0]  h_m1,
  input  logic [CIDX-1:0]      ch_m1,
  output logic                 drop,
  output icv_item_t            item,
  output logic [ADDR_BITS-1:0] idx
);

  logic [ROW_BITS-1:0]  in_row;
  logic [DIM_BITS-1:0]  in_col;
  logic [CIDX-1:0]      in_chan;
  logic [ADDR_BITS-1:0] lin;
  logic [DIM_BITS-1:0]  out_row;
  logic [DIM_BITS-1:0]  out_col;
  logic [CIDX-1:0]      out_chan;
  logic                 in_frame;

  // Item classification from the current positions
  always_comb begin
    in_frame      = in_row <= {1'b0, h_m1};
    drop          = mode && in_frame;
    idx           = lin;
    item.newv     = in_frame ? pixel_value : '0;
    item.up_ok    = in_row >= ROW_BITS'(2);
    item.lo_ok    = in_row != '0;
    item.emit     = (in_row >= ROW_BITS'(2)) || ((in_row == ROW_BITS'(1)) && (in_col != '0));
    item.top_ok   = out_row != '0;
    item.bot_ok   = out_row < h_m1;
    item.left_ok  = out_col != '0;
    item.right_ok = out_col < w_m1;
    item.done     = (out_row == h_m1) && (out_col == w_m1) && (out_chan == ch_m1);
  end

  // Counter update per processed transaction
  always_ff @(posedge clk) begin
    if (rst || clear || (proc && item.emit && item.done)) begin
      in_row   <= '0;
      in_col   <= '0;
      in_chan  <= '0;
      lin      <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_chan <= '0;
    end else if (proc) begin
      if (in_chan == ch_m1) begin
        in_chan <= '0;
        if (in_col == w_m1) begin
          in_col <= '0;
          in_row <= in_row + ROW_BITS'(1);
          lin    <= '0;
        end else begin
          in_col <= in_col + DIM_BITS'(1);
          lin    <= lin + ADDR_BITS'(1);
        end
      end else begin
        in_chan <= in_chan + CIDX'(1);
        lin     <= lin + ADDR_BITS'(1);
      end
      if (item.emit) begin
        if (out_chan == ch_m1) begin
          out_chan <= '0;
          if (out_col == w_m1) begin
            out_col <= '0;
            out_row <= out_row + DIM_BITS'(1);
          end else begin
            out_col <= out_col + DIM_BITS'(1);
          end
        end else begin
          out_chan <= out_chan + CIDX'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && item.emit && item.done) |=> (in_row == '0 && out_row == '0 && out_col == '0))
    else $error("frame end did not clear positions");
  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    clear |=> (in_row == '0 && lin == '0 && out_chan == '0))
    else $error("geometry write did not clear positions");
  a_out_lags_in: assert property (@(posedge clk) disable iff (rst)
    {1'b0, out_row} <= in_row)
    else $error("output row ahead of input row");
`endif

endmodule

>>> hdl/icv_window.sv
// Line store read-modify-write with forwarding, per-channel column delay
// lines, and the masked 3x3 window register. Depends on icv_pkg, icv_ram.
module icv_window import icv_pkg::*; #(
  parameter int ADDR_BITS = 13,
  parameter int DEPTH = 8192,
  parameter int MAX_CHANNELS = 4,
  parameter int CIDX = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      s0_valid,
  input  icv_item_t                 s0_item,
  input  logic [ADDR_BITS-1:0]      s0_idx,
  input  logic [CIDX-1:0]           ch_m1,
  output logic                      win_valid,
  output logic                      win_done,
  output logic [TAP_COUNT-1:0][PIX_BITS-1:0] win
);

  logic                   s1_valid;
  icv_item_t              s1_item;
  logic [ADDR_BITS-1:0]   s1_idx;
  logic                   fwd_hit;
  logic [2*PIX_BITS-1:0]  fwd_data;
  logic [2*PIX_BITS-1:0]  rd_data;
  logic [2*PIX_BITS-1:0]  ramd;
  logic [2*PIX_BITS-1:0]  wr_data;
  pix_t                   up, lo;
  pix_t                   du1 [MAX_CHANNELS];
  pix_t                   dl1 [MAX_CHANNELS];
  pix_t                   dn1 [MAX_CHANNELS];
  pix_t                   du0 [MAX_CHANNELS];
  pix_t                   dl0 [MAX_CHANNELS];
  pix_t                   dn0 [MAX_CHANNELS];
  pix_t                   cu1, cl1, cn1, cu0, cl0, cn0;
  logic                   shift;

  // Line store: upper byte is the row two above, lower byte the row above
  icv_ram #(.WIDTH(2*PIX_BITS), .DEPTH(DEPTH)) u_lines (
    .clk     (clk),
    .wr_en   (adv && s1_valid),
    .wr_addr (s1_idx),
    .wr_data (wr_data),
    .rd_en   (adv && s0_valid),
    .rd_addr (s0_idx),
    .rd_data (rd_data)
  );

  // Read data with forwarding of a write at the same edge as the read
  always_comb begin
    ramd    = fwd_hit ? fwd_data : rd_data;
    up      = s1_item.up_ok ? ramd[2*PIX_BITS-1:PIX_BITS] : '0;
    lo      = s1_item.lo_ok ? ramd[PIX_BITS-1:0] : '0;
    wr_data = {lo, s1_item.newv};
    shift   = adv && s1_valid;
    cu1     = du1[ch_m1];
    cl1     = dl1[ch_m1];
    cn1     = dn1[ch_m1];
    cu0     = du0[ch_m1];
    cl0     = dl0[ch_m1];
    cn0     = dn0[ch_m1];
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      win_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= s0_valid;
      win_valid <= s1_valid && s1_item.emit;
    end
  end

  // Stage 1 payload and forwarding record
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item  <= s0_item;
      s1_idx   <= s0_idx;
      fwd_hit  <= s1_valid && (s1_idx == s0_idx);
      fwd_data <= wr_data;
    end
  end

  // Column delay lines, one step per processed transaction
  always_ff @(posedge clk) begin
    if (shift) begin
      du1[0] <= up;
      dl1[0] <= lo;
      dn1[0] <= s1_item.newv;
      du0[0] <= cu1;
      dl0[0] <= cl1;
      dn0[0] <= cn1;
      for (int k = 1; k < MAX_CHANNELS; k++) begin
        du1[k] <= du1[k-1];
        dl1[k] <= dl1[k-1];
        dn1[k] <= dn1[k-1];
        du0[k] <= du0[k-1];
        dl0[k] <= dl0[k-1];
        dn0[k] <= dn0[k-1];
      end
    end
  end

  // Window register, taps outside the frame forced to zero
  always_ff @(posedge clk) begin
    if (adv) begin
      win_done <= s1_item.done;
      win[0] <= (s1_item.top_ok && s1_item.left_ok)  ? cu0 : '0;
      win[1] <=  s1_item.top_ok                      ? cu1 : '0;
      win[2] <= (s1_item.top_ok && s1_item.right_ok) ? up  : '0;
      win[3] <=  s1_item.left_ok                     ? cl0 : '0;
      win[4] <=  cl1;
      win[5] <=  s1_item.right_ok                    ? lo  : '0;
      win[6] <= (s1_item.bot_ok && s1_item.left_ok)  ? cn0 : '0;
      win[7] <=  s1_item.bot_ok                      ? cn1 : '0;
      win[8] <= (s1_item.bot_ok && s1_item.right_ok) ? s1_item.newv : '0;
    end
  end

endmodule

>>> hdl/icv_mac.sv
// Nine multiplies, two-level adder tree, floor and clamp to a byte,
// ending in the output register. Depends on icv_pkg.
module icv_mac import icv_pkg::*; #(
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic                               in_done,
  input  logic [TAP_COUNT-1:0][PIX_BITS-1:0] win,
  input  logic [ROW_COEFS-1:0][KROW_BITS-1:0] kernel,
  output logic                               out_valid,
  output pix_t                               out_value,
  output logic                               out_done
);

  localparam int PROD_BITS = PIX_BITS + 1 + COEF_BITS;
  localparam int PART_BITS = PROD_BITS + 2;
  localparam int SUM_BITS  = PART_BITS + 2;
  localparam int LIMIT     = (PIX_MAX + 1) << COEF_FRAC_BITS;

  logic signed [PROD_BITS-1:0] prod_next [TAP_COUNT];
  logic signed [PROD_BITS-1:0] prod [TAP_COUNT];
  logic signed [PART_BITS-1:0] part [ROW_COEFS];
  logic signed [SUM_BITS-1:0]  sum;
  pix_t                        result;
  logic                        v3, v4, d3, d4;

  // Tap times coefficient, left column in the low bits of each row
  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_mul
    assign prod_next[i] = $signed({1'b0, win[i]})
      * $signed(kernel[i / ROW_COEFS][(i % ROW_COEFS) * COEF_BITS +: COEF_BITS]);
  end

  // Final sum, floor and clamp
  always_comb begin
    sum = SUM_BITS'(part[0]) + SUM_BITS'(part[1]) + SUM_BITS'(part[2]);
    if (sum < 0) begin
      result = '0;
    end else if (sum >= $signed(SUM_BITS'(LIMIT))) begin
      result = PIX_BITS'(PIX_MAX);
    end else begin
      result = sum[COEF_FRAC_BITS +: PIX_BITS];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v3        <= in_valid;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      d3 <= in_done;
      d4 <= d3;
      out_done <= d4;
      out_value <= result;
      for (int i = 0; i < TAP_COUNT; i++) begin
        prod[i] <= prod_next[i];
      end
      for (int r = 0; r < ROW_COEFS; r++) begin
        part[r] <= PART_BITS'(prod[3*r]) + PART_BITS'(prod[3*r+1]) + PART_BITS'(prod[3*r+2]);
      end
    end
  end

endmodule

>>> hdl/image_convolution_3x3.sv
// 3x3 convolution of an interleaved-channel byte stream, zero padded and
// clamped to 0..255. One transaction is accepted per clock while the output
// is not stalled; a result leaves after the transaction that completes its
// neighbourhood has passed the line store read, the window register, the
// multiply stage, the adder tree and the output register.
// Results lag the input by one row plus one pixel (width*channels+channels
// bytes); send that many flush transactions after a frame to drain it. The
// line store is a single dual-port RAM with read-modify-write and
// forwarding; no clearing pass is needed. Depends on icv_pkg, the stream
// interfaces, icv_seq, icv_window, icv_mac and icv_ram.
module image_convolution_3x3 import icv_pkg::*; #(
  parameter int MAX_WIDTH      = 2048,
  parameter int MAX_CHANNELS   = 4,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  icv_in_if.sink               pixel_in,
  icv_out_if.source            result_out,
  input  logic                 cfg_write,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [KROW_BITS-1:0] cfg_data
);

  localparam int DEPTH     = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CIDX      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  function automatic logic [DIM_BITS-1:0] width_m1(input logic [DIM_BITS-1:0] v);
    if (v == '0) return '0;
    if (int'(v) > MAX_WIDTH) return DIM_BITS'(MAX_WIDTH - 1);
    return v - DIM_BITS'(1);
  endfunction

  function automatic logic [CIDX-1:0] chan_m1(input logic [CHCFG_BITS-1:0] v);
    if (v == '0) return '0;
    if (int'(v) > MAX_CHANNELS) return CIDX'(MAX_CHANNELS - 1);
    return CIDX'(v - CHCFG_BITS'(1));
  endfunction

  logic [DIM_BITS-1:0]                w_m1, h_m1;
  logic [CIDX-1:0]                    ch_m1;
  logic [ROW_COEFS-1:0][KROW_BITS-1:0] kernel;
  logic                               clear;
  logic                               adv, drop, proc;
  icv_item_t                          item;
  logic [ADDR_BITS-1:0]               idx;
  logic                               win_valid, win_done;
  logic [TAP_COUNT-1:0][PIX_BITS-1:0] win;

  // Configuration registers, geometry stored as effective values minus one
  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1      <= width_m1(DIM_BITS'(640));
      h_m1      <= DIM_BITS'(479);
      ch_m1     <= chan_m1(CHCFG_BITS'(3));
      kernel[0] <= '0;
      kernel[1] <= KROW_BITS'(1) << (COEF_BITS + COEF_FRAC_BITS);
      kernel[2] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   w_m1 <= width_m1(cfg_data[DIM_BITS-1:0]);
        REG_FRAME_HEIGHT:  h_m1 <= (cfg_data[DIM_BITS-1:0] == '0) ? '0
                                   : cfg_data[DIM_BITS-1:0] - DIM_BITS'(1);
        REG_CHANNEL_COUNT: ch_m1 <= chan_m1(cfg_data[CHCFG_BITS-1:0]);
        REG_KERNEL_TOP:    kernel[0] <= cfg_data;
        REG_KERNEL_MIDDLE: kernel[1] <= cfg_data;
        REG_KERNEL_BOTTOM: kernel[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Geometry writes restart the frame
  assign clear = cfg_write && ((cfg_index == REG_FRAME_WIDTH)
                 || (cfg_index == REG_FRAME_HEIGHT) || (cfg_index == REG_CHANNEL_COUNT));

  // Whole pipeline moves together unless the output register is held
  assign adv            = !result_out.valid || result_out.ready;
  assign pixel_in.ready = adv;
  assign proc           = pixel_in.valid && adv && !drop;

  icv_seq #(.ADDR_BITS(ADDR_BITS), .CIDX(CIDX)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .clear       (clear),
    .proc        (proc),
    .mode        (pixel_in.mode),
    .pixel_value (pixel_in.pixel_value),
    .w_m1        (w_m1),
    .h_m1        (h_m1),
    .ch_m1       (ch_m1),
    .drop        (drop),
    .item        (item),
    .idx         (idx)
  );

  icv_window #(
    .ADDR_BITS(ADDR_BITS), .DEPTH(DEPTH), .MAX_CHANNELS(MAX_CHANNELS), .CIDX(CIDX)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s0_valid  (proc),
    .s0_item   (item),
    .s0_idx    (idx),
    .ch_m1     (ch_m1),
    .win_valid (win_valid),
    .win_done  (win_done),
    .win       (win)
  );

  icv_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (win_valid),
    .in_done   (win_done),
    .win       (win),
    .kernel    (kernel),
    .out_valid (result_out.valid),
    .out_value (result_out.filtered_value),
    .out_done  (result_out.frame_done)
  );

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.ready) |-> !pixel_in.ready)
    else $error("input taken while output stalled");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_out.valid)
    else $error("result valid right after reset");
  a_drop_no_proc: assert property (@(posedge clk) disable iff (rst)
    drop |-> !proc)
    else $error("early flush entered the pipeline");
`endif

endmodule
